>>> hdl/edit_distance_engine_defines.svh
// Assertion helpers shared by the edit distance engine.
`ifndef EDIT_DISTANCE_ENGINE_DEFINES_SVH
`define EDIT_DISTANCE_ENGINE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define EDE_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define EDE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/ede_pkg.sv
`timescale 1ns / 1ps

package ede_pkg;

	localparam int unsigned SYM_W  = 8;
	localparam int unsigned DIST_W = 7;

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_STREAM = 1'b1
	} cmd_t;

	// control part of a token moving down the cell row
	typedef struct packed {
		logic             valid;
		logic             last;
		logic             adv;
		logic             ovf;
		logic [SYM_W-1:0] sym;
	} tok_ctl_t;

	// first-string load broadcast to the cells
	typedef struct packed {
		logic             init;
		logic             we;
		logic [SYM_W-1:0] sym;
	} ld_ctl_t;

endpackage

>>> hdl/ede_in_if.sv
`timescale 1ns / 1ps

interface ede_in_if;
	logic                           valid;
	logic                           ready;
	ede_pkg::cmd_t                  cmd;
	logic [ede_pkg::SYM_W-1:0]      symbol;
	logic                           is_last;

	modport source (output valid, cmd, symbol, is_last, input ready);
	modport sink (input valid, cmd, symbol, is_last, output ready);
endinterface

>>> hdl/ede_out_if.sv
`timescale 1ns / 1ps

interface ede_out_if;
	logic                           valid;
	logic                           ready;
	logic [ede_pkg::DIST_W-1:0]     distance;
	logic                           overflow;

	modport source (output valid, distance, overflow, input ready);
	modport sink (input valid, distance, overflow, output ready);
endinterface

>>> hdl/ede_head.sv
`timescale 1ns / 1ps

module ede_head #(
	parameter int unsigned MAX_LEN = 64,
	localparam int unsigned W = $clog2(MAX_LEN + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      acc,
	input  logic                      en,
	input  ede_pkg::cmd_t             cmd,
	input  logic [ede_pkg::SYM_W-1:0] sym,
	input  logic                      last,
	output ede_pkg::tok_ctl_t         tok_s0,
	output logic [W-1:0]              left_s0,
	output logic [W-1:0]              diag_s0,
	output ede_pkg::ld_ctl_t          ld_s0,
	output logic [W-1:0]              widx_s0
);

	logic [W-1:0] first_len_q;
	logic [W-1:0] sec_idx_q;
	logic         ovf_seen_q;
	logic         first_over_q;
	logic         load_closed_q;

	logic         start;
	logic [W-1:0] len;
	logic         room;
	logic         adv;
	logic         is_load;
	logic         is_stream;

	// a load word while the load is closed begins a new first string
	assign start     = load_closed_q;
	assign len       = start ? '0 : first_len_q;
	assign room      = len < W'(MAX_LEN);
	assign adv       = sec_idx_q < W'(MAX_LEN);
	assign is_load   = acc && (cmd == ede_pkg::CMD_LOAD);
	assign is_stream = acc && (cmd == ede_pkg::CMD_STREAM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_len_q   <= '0;
			sec_idx_q     <= '0;
			ovf_seen_q    <= 1'b0;
			first_over_q  <= 1'b0;
			load_closed_q <= 1'b1;
		end else if (acc) begin
			unique case (cmd)
				ede_pkg::CMD_LOAD: begin
					if (start) begin
						sec_idx_q <= '0;
					end
					first_len_q   <= room ? len + W'(1) : len;
					first_over_q  <= (!start && first_over_q) || !room;
					ovf_seen_q    <= (!start && ovf_seen_q) || !room;
					load_closed_q <= last;
				end
				ede_pkg::CMD_STREAM: begin
					load_closed_q <= 1'b1;
					if (last) begin
						sec_idx_q  <= '0;
						ovf_seen_q <= first_over_q;
					end else if (adv) begin
						sec_idx_q <= sec_idx_q + W'(1);
					end else begin
						ovf_seen_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s0 <= '0;
			ld_s0  <= '0;
		end else begin
			if (en) begin
				tok_s0.valid <= is_stream;
				tok_s0.last  <= last;
				tok_s0.adv   <= adv;
				tok_s0.ovf   <= ovf_seen_q || !adv;
				tok_s0.sym   <= sym;
			end
			ld_s0.init <= is_load && start;
			ld_s0.we   <= is_load && room;
			ld_s0.sym  <= sym;
		end
	end

	// column zero of the new row is the second-string index plus one (held at MAX_LEN once full); diag is the index
	always_ff @(posedge clk) begin
		if (en) begin
			left_s0 <= adv ? sec_idx_q + W'(1) : sec_idx_q;
			diag_s0 <= sec_idx_q;
		end
		widx_s0 <= len;
	end

endmodule

>>> hdl/ede_cell.sv
`timescale 1ns / 1ps

module ede_cell #(
	parameter int unsigned MAX_LEN = 64,
	parameter int unsigned IDX = 1,
	localparam int unsigned W = $clog2(MAX_LEN + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  ede_pkg::ld_ctl_t  ld,
	input  logic [W-1:0]      widx,
	input  ede_pkg::tok_ctl_t tin,
	input  logic [W-1:0]      lin,
	input  logic [W-1:0]      din,
	output ede_pkg::tok_ctl_t tout,
	output logic [W-1:0]      lout,
	output logic [W-1:0]      dout
);

	logic [ede_pkg::SYM_W-1:0] ch_q;
	logic [W-1:0]              val_q;
	logic                      act_q;

	logic                      wsel;
	logic                      hit;
	logic [W-1:0]              m1;
	logic [W-1:0]              m;
	logic [W-1:0]              newv;

	assign wsel = ld.we && (widx == W'(IDX - 1));
	assign hit  = ch_q == tin.sym;
	assign m1   = (lin < din) ? lin : din;
	assign m    = (val_q < m1) ? val_q : m1;
	assign newv = hit ? din : m + W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			val_q <= W'(IDX);
			tout  <= '0;
		end else begin
			if (ld.init) begin
				act_q <= 1'b0;
				val_q <= W'(IDX);
			end
			if (wsel) begin
				act_q <= 1'b1;
			end
			if (en && tin.valid) begin
				// closing word puts the row back to index values
				if (tin.last) begin
					val_q <= W'(IDX);
				end else if (act_q && tin.adv) begin
					val_q <= newv;
				end
			end
			if (en) begin
				tout <= tin;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wsel) begin
			ch_q <= ld.sym;
		end
		if (en) begin
			// cells past the first string just forward the running value
			lout <= act_q ? (tin.adv ? newv : val_q) : lin;
			dout <= val_q;
		end
	end

endmodule

>>> hdl/edit_distance_engine.sv
// Stream words: accepted one per cycle while no result is stalled; the closing word's result passes
// through the head register, the row of MAX_LEN cells and the output register.
// Load words: one per cycle while no result is stalled; every load word waits until the
// cell row is empty.
// Reset (arst_n low): empty first string, load closed, row at index values, no result.
`timescale 1ns / 1ps
`include "edit_distance_engine_defines.svh"

module edit_distance_engine #(
	parameter int unsigned MAX_LEN = 64
) (
	input logic       clk,
	input logic       arst_n,
	ede_in_if.sink    item,
	ede_out_if.source result
);

	localparam int unsigned W     = $clog2(MAX_LEN + 1);
	localparam int unsigned CNT_W = $clog2(MAX_LEN + 2);

	ede_pkg::tok_ctl_t tok_c [0:MAX_LEN];
	logic [W-1:0]      lft [0:MAX_LEN];
	logic [W-1:0]      dg [0:MAX_LEN];
	ede_pkg::ld_ctl_t  ld;
	logic [W-1:0]      widx;

	logic                      stall;
	logic                      acc;
	logic                      load_acc;
	logic                      inc;
	logic                      dec;
	logic                      res_take;
	logic [CNT_W-1:0]          inflight_q;
	logic                      out_valid_q;
	logic [ede_pkg::DIST_W-1:0] dist_q;
	logic                      ovf_q;

	// whole row freezes while a result waits
	assign stall      = out_valid_q && !result.ready;
	assign item.ready = !stall && ((item.cmd == ede_pkg::CMD_STREAM) || (inflight_q == '0));
	assign acc        = item.valid && item.ready;
	assign load_acc   = acc && (item.cmd == ede_pkg::CMD_LOAD);
	assign inc        = acc && (item.cmd == ede_pkg::CMD_STREAM);
	assign dec        = tok_c[MAX_LEN].valid && !stall;
	assign res_take   = tok_c[MAX_LEN].valid && tok_c[MAX_LEN].last;

	ede_head #(
		.MAX_LEN(MAX_LEN)
	) u_head (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.en     (!stall),
		.cmd    (item.cmd),
		.sym    (item.symbol),
		.last   (item.is_last),
		.tok_s0 (tok_c[0]),
		.left_s0(lft[0]),
		.diag_s0(dg[0]),
		.ld_s0  (ld),
		.widx_s0(widx)
	);

	for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
		ede_cell #(
			.MAX_LEN(MAX_LEN),
			.IDX    (k)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (!stall),
			.ld    (ld),
			.widx  (widx),
			.tin   (tok_c[k-1]),
			.lin   (lft[k-1]),
			.din   (dg[k-1]),
			.tout  (tok_c[k]),
			.lout  (lft[k]),
			.dout  (dg[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (inc && !dec) begin
				inflight_q <= inflight_q + CNT_W'(1);
			end else if (dec && !inc) begin
				inflight_q <= inflight_q - CNT_W'(1);
			end
			if (!stall) begin
				out_valid_q <= res_take;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			dist_q <= ede_pkg::DIST_W'(lft[MAX_LEN]);
			ovf_q  <= tok_c[MAX_LEN].ovf;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.distance = dist_q;
	assign result.overflow = ovf_q;

	`EDE_ASSERT_NOW(a_load_drained, clk, arst_n, load_acc, inflight_q == '0, "load word with tokens in flight")
	`EDE_ASSERT_NOW(a_result_src, clk, arst_n, $rose(out_valid_q), $past(res_take), "result without closing token")
	`EDE_ASSERT_NOW(a_empty_tail, clk, arst_n, inflight_q == '0, !tok_c[MAX_LEN].valid, "tail token with zero count")
	`EDE_ASSERT_NEXT(a_load_no_tok, clk, arst_n, load_acc, !tok_c[0].valid, "token issued for load word")

endmodule

>>> dv/edit_distance_engine_tb.sv
`timescale 1ns / 1ps

module edit_distance_engine_tb;
	import ede_pkg::*;

	localparam int unsigned MAX_LEN    = 64;
	localparam int unsigned CLK_PERIOD = 10;
	localparam int unsigned N_ITEMS    = 1650;
	localparam int unsigned HOLD_CYC   = 400;
	localparam int unsigned LIMIT_CYC  = 600000;
	localparam int unsigned DIR_N      = 15;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              overflow;
	} dist_res_t;

	typedef struct {
		cmd_t              cmd;
		logic [SYM_W-1:0]  sym;
		logic              last;
		logic              typed;
		logic [DIST_W-1:0] exp_dist;
		logic              ovf;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ede_in_if  in_ch ();
	ede_out_if out_ch ();

	edit_distance_engine #(.MAX_LEN(MAX_LEN)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch),
		.result (out_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// directed words; typed rows carry a hand-computed distance
	stim_row_t dir_tab [DIR_N] = '{
		'{CMD_STREAM, 8'h00, 1'b1, 1'b1, 7'd1, 1'b0},
		'{CMD_STREAM, 8'hFF, 1'b1, 1'b1, 7'd1, 1'b0},
		'{CMD_LOAD,   8'hFF, 1'b0, 1'b0, 7'd0, 1'b0},
		'{CMD_LOAD,   8'h00, 1'b1, 1'b0, 7'd0, 1'b0},
		'{CMD_STREAM, 8'hFF, 1'b0, 1'b0, 7'd0, 1'b0},
		'{CMD_STREAM, 8'h00, 1'b1, 1'b1, 7'd0, 1'b0},
		'{CMD_STREAM, 8'h00, 1'b1, 1'b1, 7'd1, 1'b0},
		'{CMD_STREAM, 8'h55, 1'b0, 1'b0, 7'd0, 1'b0},
		'{CMD_STREAM, 8'hAA, 1'b1, 1'b1, 7'd2, 1'b0},
		'{CMD_LOAD,   8'h41, 1'b0, 1'b0, 7'd0, 1'b0},
		'{CMD_STREAM, 8'h41, 1'b1, 1'b1, 7'd0, 1'b0},
		'{CMD_LOAD,   8'h80, 1'b1, 1'b0, 7'd0, 1'b0},
		'{CMD_STREAM, 8'h7F, 1'b1, 1'b1, 7'd1, 1'b0},
		'{CMD_STREAM, 8'h80, 1'b0, 1'b0, 7'd0, 1'b0},
		'{CMD_STREAM, 8'h80, 1'b1, 1'b1, 7'd1, 1'b0}
	};

	// predictor state
	logic [SYM_W-1:0] a_chars [MAX_LEN];
	int unsigned      a_len    = 0;
	int unsigned      cost_row [MAX_LEN + 1];
	int unsigned      b_pos    = 0;
	logic             ovf_seen = 1'b0;
	logic             a_over   = 1'b0;
	logic             a_closed = 1'b1;

	dist_res_t pending_dist [$];

	int unsigned err_cnt = 0;
	int unsigned n_words = 0;
	int unsigned cycles  = 0;
	int unsigned tx_idle_pct = 17;
	int unsigned rx_idle_pct = 17;
	logic        hold_go = 1'b0;
	logic        hold_rx = 1'b0;

	// tb-side tag that travels with the word on the input channel
	logic              row_typed = 1'b0;
	logic [DIST_W-1:0] row_dist  = '0;
	logic              row_ovf   = 1'b0;

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_cnt++;
	endtask

	function automatic void rewind_row();
		for (int k = 0; k <= MAX_LEN; k++)
			cost_row[k] = k;
		b_pos = 0;
	endfunction

	function automatic void apply_word(input cmd_t c, input logic [SYM_W-1:0] s, input logic l,
		output logic got, output dist_res_t r);
		int unsigned diag;
		int unsigned up;
		int unsigned nxt;
		got = 1'b0;
		r   = '0;
		if (c == CMD_LOAD) begin
			if (a_closed) begin
				a_len    = 0;
				b_pos    = 0;
				a_over   = 1'b0;
				ovf_seen = 1'b0;
				a_closed = 1'b0;
			end
			if (a_len < MAX_LEN) begin
				a_chars[a_len] = s;
				a_len++;
			end else begin
				a_over   = 1'b1;
				ovf_seen = 1'b1;
			end
			if (l) begin
				rewind_row();
				a_closed = 1'b1;
			end
			return;
		end
		// stream word while a load is open closes it at its current length
		if (!a_closed) begin
			rewind_row();
			a_closed = 1'b1;
		end
		if (b_pos < MAX_LEN) begin
			diag        = cost_row[0];
			cost_row[0] = b_pos + 1;
			for (int k = 1; k <= a_len; k++) begin
				up = cost_row[k];
				if (a_chars[k - 1] == s) begin
					nxt = diag;
				end else begin
					nxt = cost_row[k - 1];
					if (diag < nxt) nxt = diag;
					if (up < nxt) nxt = up;
					nxt = nxt + 1;
				end
				diag        = up;
				cost_row[k] = nxt;
			end
			b_pos++;
		end else begin
			ovf_seen = 1'b1;
		end
		if (l) begin
			got        = 1'b1;
			r.distance = DIST_W'(cost_row[a_len]);
			r.overflow = ovf_seen;
			rewind_row();
			ovf_seen = a_over;
		end
	endfunction

	function automatic int unsigned pick_len();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 88) return $urandom_range(1, 8);
		if (roll < 96) return $urandom_range(9, MAX_LEN - 2);
		return $urandom_range(MAX_LEN - 1, MAX_LEN + 3);
	endfunction

	// mostly a narrow alphabet around a base so matches are common
	function automatic logic [SYM_W-1:0] pick_sym(input logic [SYM_W-1:0] base);
		if ($urandom_range(99) < 65)
			return {base[SYM_W-1:2], 2'($urandom_range(3))};
		return SYM_W'($urandom_range(255));
	endfunction

	task automatic send_word(input cmd_t c, input logic [SYM_W-1:0] s, input logic l,
		input logic typed = 1'b0, input logic [DIST_W-1:0] d = '0, input logic o = 1'b0);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.cmd     <= c;
		in_ch.symbol  <= s;
		in_ch.is_last <= l;
		row_typed     <= typed;
		row_dist      <= d;
		row_ovf       <= o;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		n_words++;
	endtask

	always @(posedge clk)
		out_ch.ready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);

	// long receiver stall so the cell row backs up into the input
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYC) @(posedge clk);
		hold_rx <= 1'b0;
	end

	always @(posedge clk) begin : track_input
		logic      got;
		dist_res_t r;
		if (!arst_n) begin
			// empty first string, load closed
			a_len    = 0;
			ovf_seen = 1'b0;
			a_over   = 1'b0;
			a_closed = 1'b1;
			rewind_row();
		end else if (in_ch.valid && in_ch.ready) begin
			apply_word(in_ch.cmd, in_ch.symbol, in_ch.is_last, got, r);
			if (got) begin
				if (row_typed) begin
					r.distance = row_dist;
					r.overflow = row_ovf;
				end
				pending_dist.push_back(r);
			end
		end
	end

	always @(posedge clk) begin : chk_result
		dist_res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_dist.size() == 0) begin
				flag_error($sformatf("unexpected result distance=%0d overflow=%0b",
					out_ch.distance, out_ch.overflow));
			end else begin
				want = pending_dist.pop_front();
				if (out_ch.distance !== want.distance)
					flag_error($sformatf("distance %0d, expected %0d",
						out_ch.distance, want.distance));
				if (out_ch.overflow !== want.overflow)
					flag_error($sformatf("overflow %0b, expected %0b",
						out_ch.overflow, want.overflow));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYC) begin
			$display("TIMEOUT after %0d cycles, %0d words sent", cycles, n_words);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		logic [SYM_W-1:0] base;
		int unsigned      n_len;
		int unsigned      n_cmp;
		int unsigned      roll;
		logic             open_load;

		in_ch.valid   = 1'b0;
		in_ch.cmd     = CMD_LOAD;
		in_ch.symbol  = '0;
		in_ch.is_last = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			send_word(dir_tab[i].cmd, dir_tab[i].sym, dir_tab[i].last,
				dir_tab[i].typed, dir_tab[i].exp_dist, dir_tab[i].ovf);

		while (n_words < N_ITEMS) begin
			if (!hold_go && n_words >= 300)
				hold_go = 1'b1;
			if (n_words >= 700 && n_words < 1000) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end else begin
				tx_idle_pct = 17;
				rx_idle_pct <= 17;
			end
			base = SYM_W'($urandom_range(255));
			roll = $urandom_range(99);
			if (roll < 6) begin
				// stray word
				send_word($urandom_range(1) ? CMD_STREAM : CMD_LOAD,
					SYM_W'($urandom_range(255)), 1'($urandom_range(1)));
			end else begin
				// new first string, sometimes left open for the stream to close
				if (roll >= 15) begin
					n_len     = pick_len();
					open_load = ($urandom_range(99) < 12);
					for (int i = 0; i < n_len; i++)
						send_word(CMD_LOAD, pick_sym(base),
							(i == n_len - 1) && !open_load);
				end
				n_cmp = $urandom_range(1, 4);
				for (int j = 0; j < n_cmp; j++) begin
					n_len = pick_len();
					for (int i = 0; i < n_len; i++)
						send_word(CMD_STREAM, pick_sym(base), i == n_len - 1);
				end
			end
		end

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_dist.size() != 0) @(posedge clk);
		repeat (2 * MAX_LEN + 8) @(posedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
